>>> hdl/bsf_pkg.sv
// Shared types and constants for the 3x3 box smoothing filter.
// No dependencies.
`default_nettype none
package bsf_pkg;
	localparam int MAX_SIDE = 32;
	localparam int PIX_W = 8;
	localparam int POS_W = 5;
	localparam int SIDE_W = 6;
	localparam int SUM_W = 12;

	// one emit command from front to back
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
		logic             done;
	} cmd_t;

	// truncated divide of a 12-bit sum by 4 with a shift, or by 6 or 9 using reciprocal multiplies
	function automatic logic [PIX_W-1:0] mean_div(input logic [SUM_W-1:0] s,
			input logic [3:0] cnt);
		logic [SUM_W+12:0] p;
		logic [PIX_W-1:0] q;
		begin
			p = '0;
			q = '0;
			unique case (cnt)
				4'd4: q = s[PIX_W+1:2];
				4'd6: begin
					p = {1'b0, s} * 13'd2731; // 2^14/6 rounded up
					q = p[21:14];
				end
				default: begin
					p = {1'b0, s} * 13'd3641; // 2^15/9 rounded up
					q = p[22:15];
				end
			endcase
			mean_div = q;
		end
	endfunction

	// row index mod 3: 4 is 1 mod 3, so add the 2-bit digits and fold
	function automatic logic [1:0] mod3(input logic [POS_W-1:0] v);
		logic [2:0] s;
		begin
			s = {1'b0, v[1:0]} + {1'b0, v[3:2]} + {2'b0, v[4]};
			if (s >= 3'd6) s = s - 3'd6;
			else if (s >= 3'd3) s = s - 3'd3;
			mod3 = s[1:0];
		end
	endfunction
endpackage
`default_nettype wire

>>> hdl/box_smoothing_filter_3x3_core.sv
// Top level of the 3x3 box smoothing filter: config register, front and back.
// Depends on bsf_pkg, bsf_front, bsf_back.
`default_nettype none
// Pixels arrive in raster order; each accepted pixel causes zero, one, two or,
// at frame end, side+2 results (side clamped to 2..MAX_SIDE). Each result holds
// the back end while it takes the command, makes nine serial reads of the single
// read port of the line store, waits for the last read to land and, once the
// output is free, divides into the output register. Input stalls until the
// pixel's last command has been taken by the back end; pixels of row 0 also wait
// until the back end is idle, so a new frame never overwrites rows still being
// read. Writing side restarts the frame and drops pending results.
module box_smoothing_filter_3x3_core import bsf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [PIX_W-1:0]  pixel,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [SIDE_W-1:0] side,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [PIX_W-1:0]       smoothed,
	output logic [POS_W-1:0]       out_row,
	output logic [POS_W-1:0]       out_col,
	output logic                   last_of_run,
	output logic                   frame_done
);
	logic [SIDE_W-1:0] side_q;
	logic restart;
	logic wr_en, cmd_valid, cmd_stall;
	logic [$clog2(3*MAX_SIDE)-1:0] wr_addr;
	logic [PIX_W-1:0] wr_data;
	cmd_t cmd;

	assign cfg_ready = 1'b1;
	assign restart = cfg_valid;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_q <= SIDE_W'(MAX_SIDE);
		else if (cfg_valid) side_q <= side;
	end

	bsf_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .pixel, .side_q_i(side_q), .restart,
		.wr_en, .wr_addr, .wr_data, .cmd_valid, .cmd, .cmd_stall
	);
	bsf_back u_back (
		.clk, .arst_n, .side_q_i(side_q), .restart, .wr_en, .wr_addr, .wr_data,
		.cmd_valid, .cmd, .cmd_stall, .out_valid, .out_stall, .smoothed,
		.out_row, .out_col, .last_of_run, .frame_done
	);
endmodule
`default_nettype wire

>>> hdl/bsf_front.sv
// Front end: accepts pixels, writes the line store address, queues emit commands.
// Depends on bsf_pkg.
`default_nettype none
module bsf_front import bsf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PIX_W-1:0]     pixel,
	input  wire logic [SIDE_W-1:0]    side_q_i,
	input  wire logic                 restart,
	output logic                      wr_en,
	output logic [$clog2(3*MAX_SIDE)-1:0] wr_addr,
	output logic [PIX_W-1:0]          wr_data,
	output logic                      cmd_valid,
	output cmd_t                      cmd,
	input  wire logic                 cmd_stall
);
	localparam int AW = $clog2(3*MAX_SIDE);
	logic [POS_W-1:0] row_q, col_q;
	logic [1:0] bank_q;
	logic [POS_W-1:0] n1;
	logic [SIDE_W-1:0] n;
	// burst of pending emits
	logic busy_q;
	logic [1:0] phase_q;          // 0: diag, 1: right edge, 2: last row
	logic [POS_W-1:0] ec_q, pc_q, pr_q;
	logic has_diag_q, has_edge_q, has_frame_q;
	logic acc;

	always_comb begin
		n = side_q_i;
		if (n < SIDE_W'(2)) n = SIDE_W'(2);
		if (n > SIDE_W'(MAX_SIDE)) n = SIDE_W'(MAX_SIDE);
		n1 = POS_W'(n - SIDE_W'(1));
	end

	// row 0 of a new frame waits for the back end to finish reading the old last rows
	assign in_stall = busy_q || (cmd_stall && (row_q == '0));
	assign acc = in_valid && !in_stall;
	assign wr_en = acc;
	assign wr_addr = AW'(bank_q * MAX_SIDE + col_q);
	assign wr_data = pixel;

	// pending command selection
	logic more;
	always_comb begin
		cmd = '0;
		cmd.done = 1'b0;
		priority if (phase_q == 2'd0 && has_diag_q) begin
			cmd.row = pr_q - POS_W'(1);
			cmd.col = pc_q - POS_W'(1);
			more = has_edge_q || has_frame_q;
		end else if (phase_q <= 2'd1 && has_edge_q) begin
			cmd.row = pr_q - POS_W'(1);
			cmd.col = n1;
			more = has_frame_q;
		end else begin
			cmd.row = n1;
			cmd.col = ec_q;
			cmd.done = (ec_q == n1);
			more = (ec_q != n1);
		end
		cmd.last = !more;
	end
	assign cmd_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0; col_q <= '0; bank_q <= '0; busy_q <= 1'b0;
			phase_q <= '0; ec_q <= '0; pc_q <= '0; pr_q <= '0;
			has_diag_q <= 1'b0; has_edge_q <= 1'b0; has_frame_q <= 1'b0;
		end else if (restart) begin
			row_q <= '0; col_q <= '0; bank_q <= '0; busy_q <= 1'b0;
		end else begin
			if (busy_q && !cmd_stall) begin
				if (cmd.last) busy_q <= 1'b0;
				else if (phase_q == 2'd0 && has_diag_q) begin
					phase_q <= has_edge_q ? 2'd1 : 2'd2;
				end else if (phase_q <= 2'd1 && has_edge_q) phase_q <= 2'd2;
				else ec_q <= ec_q + POS_W'(1);
			end
			if (acc) begin
				pr_q <= row_q;
				pc_q <= col_q;
				has_diag_q <= (row_q != 0) && (col_q != 0);
				has_edge_q <= (row_q != 0) && (col_q == n1);
				has_frame_q <= (row_q == n1) && (col_q == n1);
				ec_q <= '0;
				phase_q <= '0;
				busy_q <= ((row_q != 0) && (col_q != 0));
				if (col_q == n1) begin
					col_q <= '0;
					if (row_q == n1) begin
						row_q <= '0; bank_q <= '0;
					end else begin
						row_q <= row_q + POS_W'(1);
						bank_q <= (bank_q == 2'd2) ? 2'd0 : bank_q + 2'd1;
					end
				end else col_q <= col_q + POS_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/bsf_back.sv
// Back end: line store, 3x3 window gather over cycles, divide, output register.
// Depends on bsf_pkg.
`default_nettype none
module bsf_back import bsf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [SIDE_W-1:0]    side_q_i,
	input  wire logic                 restart,
	input  wire logic                 wr_en,
	input  wire logic [$clog2(3*MAX_SIDE)-1:0] wr_addr,
	input  wire logic [PIX_W-1:0]     wr_data,
	input  wire logic                 cmd_valid,
	input  wire cmd_t                 cmd,
	output logic                      cmd_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [PIX_W-1:0]          smoothed,
	output logic [POS_W-1:0]          out_row,
	output logic [POS_W-1:0]          out_col,
	output logic                      last_of_run,
	output logic                      frame_done
);
	localparam int AW = $clog2(3*MAX_SIDE);
	logic [PIX_W-1:0] mem [3*MAX_SIDE];
	logic [PIX_W-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic [SIDE_W-1:0] n;
	logic [POS_W-1:0] n1;
	typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV} st_t;
	st_t st_q;
	logic [1:0] ky_q, kx_q;   // tap row and column offset 0..2
	logic rd_v_q;
	logic tap_ok_q;
	logic [SUM_W-1:0] sum_q;
	logic [3:0] cnt_q;
	cmd_t c_q;
	logic [POS_W-1:0] ty, tx;
	logic tok;
	logic fire;
	logic signed [POS_W+1:0] yy, xx;

	always_comb begin
		n = side_q_i;
		if (n < SIDE_W'(2)) n = SIDE_W'(2);
		if (n > SIDE_W'(MAX_SIDE)) n = SIDE_W'(MAX_SIDE);
		n1 = POS_W'(n - SIDE_W'(1));
		yy = $signed({2'b0, c_q.row}) + $signed({5'b0, ky_q}) - 7'sd1;
		xx = $signed({2'b0, c_q.col}) + $signed({5'b0, kx_q}) - 7'sd1;
		tok = (yy >= 0) && (xx >= 0) && (yy <= $signed({2'b0, n1}))
			&& (xx <= $signed({2'b0, n1}));
		ty = POS_W'(yy);
		tx = POS_W'(xx);
		rd_addr = AW'(mod3(ty) * MAX_SIDE + tx);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign cmd_stall = (st_q != S_IDLE);
	// last read has landed and the output register is free
	assign fire = (st_q == S_DIV) && !rd_v_q && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_valid <= 1'b0; rd_v_q <= 1'b0;
			ky_q <= '0; kx_q <= '0; tap_ok_q <= 1'b0; sum_q <= '0; cnt_q <= '0;
			c_q <= '0; smoothed <= '0; out_row <= '0; out_col <= '0;
			last_of_run <= 1'b0; frame_done <= 1'b0;
		end else if (restart) begin
			st_q <= S_IDLE; out_valid <= 1'b0; rd_v_q <= 1'b0;
		end else begin
			if (fire) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			rd_v_q <= (st_q == S_READ);
			if (st_q == S_IDLE) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else if (rd_v_q && tap_ok_q) begin
				sum_q <= sum_q + SUM_W'(rd_q);
				cnt_q <= cnt_q + 4'd1;
			end
			unique case (st_q)
				S_IDLE: if (cmd_valid) begin
					c_q <= cmd; ky_q <= '0; kx_q <= '0; st_q <= S_READ;
				end
				S_READ: begin
					tap_ok_q <= tok;
					if (ky_q == 2'd2 && kx_q == 2'd2) st_q <= S_DIV;
					else if (kx_q == 2'd2) begin
						kx_q <= '0;
						ky_q <= ky_q + 2'd1;
					end else kx_q <= kx_q + 2'd1;
				end
				S_DIV: if (fire) begin
					smoothed <= mean_div(sum_q, cnt_q);
					out_row <= c_q.row; out_col <= c_q.col;
					last_of_run <= c_q.last; frame_done <= c_q.done;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/bsf_checker.sv
// Port-level checks for the box smoothing filter, bound to the top level.
// Depends on box_smoothing_filter_3x3_core.
`default_nettype none
module bsf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic last_of_run,
	input wire logic frame_done,
	input wire logic cfg_valid
);
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run) else $error("frame_done without last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && !cfg_valid |=> out_valid) else $error("result dropped");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> !out_valid) else $error("result after restart");
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid && !in_stall)
		else $error("busy out of reset");
endmodule
bind box_smoothing_filter_3x3_core bsf_checker u_chk (.*);
`default_nettype wire

>>> sim/box_smoothing_filter_3x3_core_test.sv
// Self-checking testbench for box_smoothing_filter_3x3_core: random pixel frames at several sides.
// Depends on bsf_pkg and the filter RTL; carries its own line-store model of the filter.
`default_nettype none
module box_smoothing_filter_3x3_core_test;
	import bsf_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] smoothed;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
		logic             done;
	} mean_result_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] pixel = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SIDE_W-1:0] side = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] smoothed;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic last_of_run;
	logic frame_done;

	logic [PIX_W-1:0] pixel_queue[$];
	mean_result_t expected_means[$];

	// filter model state
	logic [PIX_W-1:0] line_store[3*32];
	int unsigned cur_row = 0;
	int unsigned cur_col = 0;
	logic [SIDE_W-1:0] side_reg = 6'd32;

	int idle_mode = 0;
	int accepted_pixels = 0;
	int hold_cycles = 0;
	bit hold_started = 0;
	int cycle_count = 0;
	int error_count = 0;

	box_smoothing_filter_3x3_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .side(side),
		.out_valid(out_valid), .out_stall(out_stall), .smoothed(smoothed),
		.out_row(out_row), .out_col(out_col), .last_of_run(last_of_run),
		.frame_done(frame_done)
	);

	always #10 clk = ~clk;

	function automatic int unsigned side_eff();
		int unsigned n;
		n = side_reg;
		if (n < 2) n = 2;
		if (n > 32) n = 32;
		return n;
	endfunction

	function automatic void push_mean(int unsigned r, int unsigned c, int unsigned n);
		int unsigned sum, cnt, r0, r1, c0, c1;
		mean_result_t m;
		sum = 0;
		cnt = 0;
		r0 = (r > 0) ? r - 1 : 0;
		r1 = (r + 1 < n) ? r + 1 : n - 1;
		c0 = (c > 0) ? c - 1 : 0;
		c1 = (c + 1 < n) ? c + 1 : n - 1;
		for (int unsigned y = r0; y <= r1; y++)
			for (int unsigned x = c0; x <= c1; x++) begin
				sum += line_store[(y % 3) * 32 + x];
				cnt++;
			end
		m.smoothed = PIX_W'(sum / cnt);
		m.row = POS_W'(r);
		m.col = POS_W'(c);
		m.last = 1'b0;
		m.done = (r == n - 1 && c == n - 1);
		expected_means.push_back(m);
	endfunction

	// one accepted pixel: store it, queue every mean it completes
	function automatic void predict_pixel(logic [PIX_W-1:0] p);
		int unsigned n, r, c, prev_count;
		n = side_eff();
		prev_count = expected_means.size();
		if (cur_row >= n || cur_col >= n) begin
			cur_row = 0;
			cur_col = 0;
		end
		r = cur_row;
		c = cur_col;
		line_store[(r % 3) * 32 + c] = p;
		if (r >= 1) begin
			if (c >= 1) push_mean(r - 1, c - 1, n);
			if (c == n - 1) push_mean(r - 1, n - 1, n);
		end
		if (r == n - 1 && c == n - 1)
			for (int unsigned j = 0; j < n; j++) push_mean(n - 1, j, n);
		if (expected_means.size() > prev_count)
			expected_means[expected_means.size() - 1].last = 1'b1;
		c++;
		if (c >= n) begin
			c = 0;
			r++;
			if (r >= n) r = 0;
		end
		cur_row = r;
		cur_col = c;
	endfunction

	// sender
	always @(posedge clk) begin
		bit keep;
		keep = 0;
		if (in_valid && !in_stall) begin
			predict_pixel(pixel);
			accepted_pixels++;
		end else if (in_valid) begin
			keep = 1;
		end
		if (!keep) begin
			if (pixel_queue.size() > 0 && arst_n &&
					$urandom_range(99) >= (idle_mode == 0 ? 15 : idle_mode == 1 ? 76 : 0)) begin
				in_valid <= 1'b1;
				pixel <= pixel_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// one long receiver hold-off while the sender keeps offering pixels
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
		else if (!hold_started && accepted_pixels >= 60) begin
			hold_started <= 1;
			hold_cycles <= 300;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		mean_result_t m;
		if (out_valid && !out_stall) begin
			if (expected_means.size() == 0) begin
				$error("unexpected result row %0d col %0d", out_row, out_col);
				error_count++;
			end else begin
				m = expected_means.pop_front();
				if (smoothed !== m.smoothed) begin
					$error("smoothed: expected %0d, got %0d", m.smoothed, smoothed);
					error_count++;
				end
				if (out_row !== m.row) begin
					$error("out_row: expected %0d, got %0d", m.row, out_row);
					error_count++;
				end
				if (out_col !== m.col) begin
					$error("out_col: expected %0d, got %0d", m.col, out_col);
					error_count++;
				end
				if (last_of_run !== m.last) begin
					$error("last_of_run: expected %0d, got %0d", m.last, last_of_run);
					error_count++;
				end
				if (frame_done !== m.done) begin
					$error("frame_done: expected %0d, got %0d", m.done, frame_done);
					error_count++;
				end
			end
		end
		out_stall <= (hold_cycles > 0) ||
			($urandom_range(99) < (idle_mode == 0 ? 76 : idle_mode == 1 ? 15 : 0));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("box_smoothing_filter_3x3_core_test: errors");
			$finish;
		end
	end

	task automatic write_side(input logic [SIDE_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		side <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		side_reg = v;
		cur_row = 0;
		cur_col = 0;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pixel_queue.size() > 0 || in_valid || expected_means.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// count random pixels, with the extremes mixed in now and then
	task automatic queue_pixels(input int count);
		for (int i = 0; i < count; i++)
			case ($urandom_range(7))
				0: pixel_queue.push_back(8'd0);
				1: pixel_queue.push_back(8'd255);
				default: pixel_queue.push_back(PIX_W'($urandom));
			endcase
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: side 0 acts as 2 with full-scale, zero and mixed frames, then a full-scale frame at side 3
		write_side(6'd0);
		repeat (4) pixel_queue.push_back(8'd255);
		repeat (4) pixel_queue.push_back(8'd0);
		pixel_queue.push_back(8'd255);
		pixel_queue.push_back(8'd0);
		pixel_queue.push_back(8'd0);
		pixel_queue.push_back(8'd255);
		drain();
		write_side(6'd3);
		repeat (9) pixel_queue.push_back(8'd255);
		drain();

		write_side(6'd5);
		queue_pixels(25);
		drain();

		idle_mode = 1;
		write_side(6'd1);
		queue_pixels(12);
		drain();
		write_side(6'd63);
		queue_pixels(40);
		drain();

		idle_mode = 2;
		write_side(6'd2);
		queue_pixels(8);
		drain();
		write_side(6'd4);
		queue_pixels(24);
		drain();

		if (error_count == 0)
			$display("box_smoothing_filter_3x3_core_test: clean");
		else
			$display("box_smoothing_filter_3x3_core_test: errors");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
hdl/bsf_pkg.sv
hdl/bsf_front.sv
hdl/bsf_back.sv
hdl/box_smoothing_filter_3x3_core.sv
hdl/bsf_checker.sv
sim/box_smoothing_filter_3x3_core_test.sv
